### rtl/console_bus_region_decoder_core_macros.svh
// Assertion helpers for the bus region decoder.
// Each takes a label, the clock, the active-low reset, an antecedent and a consequent.
`ifndef CONSOLE_BUS_REGION_DECODER_CORE_MACROS_SVH
`define CONSOLE_BUS_REGION_DECODER_CORE_MACROS_SVH

// Same-cycle implication.
`define CBRD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("bus region decoder: same-cycle check failed");

// Next-cycle implication.
`define CBRD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("bus region decoder: next-cycle check failed");

`endif

### rtl/cbrd_pkg.sv
// ----------------------------------------------------------------------------
// cbrd_pkg
// Types, codes and the address decode shared by the bus region decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cbrd_pkg;

    localparam int unsigned LINE_WORDS_DEF    = 1024;
    localparam int unsigned GPU_RAM_WORDS_DEF = 1024;
    localparam int unsigned DSP_RAM_WORDS_DEF = 2048;
    localparam int unsigned ROM_WORDS_DEF     = 65536;
    localparam int unsigned CLUT_WORDS        = 256;

    localparam logic [16:0] ROM_WORDS_RESET = 17'h10000;
    localparam logic [15:0] NO_DATA         = 16'hFFFF;

    // request kinds
    localparam logic [2:0] KIND_WORD_WRITE = 3'd0;
    localparam logic [2:0] KIND_WORD_READ  = 3'd1;
    localparam logic [2:0] KIND_BYTE_WRITE = 3'd2;
    localparam logic [2:0] KIND_BYTE_READ  = 3'd3;
    localparam logic [2:0] KIND_ROM_LOAD   = 3'd4;

    // regions
    localparam logic [2:0] REGION_ROM  = 3'd0;
    localparam logic [2:0] REGION_NONE = 3'd1;
    localparam logic [2:0] REGION_CLUT = 3'd2;
    localparam logic [2:0] REGION_LA   = 3'd3;
    localparam logic [2:0] REGION_LB   = 3'd4;
    localparam logic [2:0] REGION_LW   = 3'd5;
    localparam logic [2:0] REGION_GPU  = 3'd6;
    localparam logic [2:0] REGION_DSP  = 3'd7;

    // region boundaries (byte addresses)
    localparam logic [23:0] WIN_BASE  = 24'h100000;
    localparam logic [23:0] WIN_END   = 24'h120000;
    localparam logic [23:0] CLUT_BASE = 24'h100400;
    localparam logic [23:0] LA_BASE   = 24'h100800;
    localparam logic [23:0] LB_BASE   = 24'h101000;
    localparam logic [23:0] LW_BASE   = 24'h101800;
    localparam logic [23:0] LW_END    = 24'h102100;
    localparam logic [23:0] GPU_BASE  = 24'h103000;
    localparam logic [23:0] GPU_END   = 24'h110000;
    localparam logic [23:0] DSP_BASE  = 24'h11B000;
    localparam logic [23:0] DSP_END   = 24'h11D000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [23:0] address;
        logic [15:0] write_data;
    } req_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        status;
    } rsp_t;

    function automatic logic [2:0] decode_region(input logic [23:0] a);
        logic [2:0] r;
        if (a < WIN_BASE || a >= WIN_END) r = REGION_ROM;
        else if (a < CLUT_BASE)           r = REGION_NONE;
        else if (a < LA_BASE)             r = REGION_CLUT;
        else if (a < LB_BASE)             r = REGION_LA;
        else if (a < LW_BASE)             r = REGION_LB;
        else if (a < LW_END)              r = REGION_LW;
        else if (a < GPU_BASE)            r = REGION_NONE;
        else if (a < GPU_END)             r = REGION_GPU;
        else if (a < DSP_BASE)            r = REGION_NONE;
        else if (a < DSP_END)             r = REGION_DSP;
        else                              r = REGION_NONE;
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/console_bus_region_decoder_core.sv
// ----------------------------------------------------------------------------
// console_bus_region_decoder_core
// Decodes 24-bit bus requests onto boot ROM, colour table, line buffers and
// the GPU and DSP local RAMs, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//  - s_valid/s_ready/s_data carry requests (kind, address, write data);
//    m_valid/m_ready/m_data carry one result per request (read data, status).
//  - cfg_wr_en/cfg_wr_data set the boot ROM size in words (mirror mask);
//    write it only while no request is in flight.
//  - A request is read from memory at acceptance and held in the working
//    stage; its result is registered into the output register, and any
//    modify and write back done, when the stage completes. No new request
//    is taken while the stage holds a request.
//  - After reset the colour table, line buffers and GPU/DSP RAMs are swept
//    to zero, one entry per cycle, across the deepest of their depths;
//    s_ready stays low meanwhile. Boot ROM contents are not cleared; load
//    it before reading.
//  - If the receiver stalls, the result is held in the output register; one
//    more request may be accepted and its result waits in the working stage.
// ----------------------------------------------------------------------------
`default_nettype none

module console_bus_region_decoder_core #(
    parameter int unsigned LINE_WORDS    = cbrd_pkg::LINE_WORDS_DEF,
    parameter int unsigned GPU_RAM_WORDS = cbrd_pkg::GPU_RAM_WORDS_DEF,
    parameter int unsigned DSP_RAM_WORDS = cbrd_pkg::DSP_RAM_WORDS_DEF,
    parameter int unsigned ROM_WORDS     = cbrd_pkg::ROM_WORDS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [16:0]    cfg_wr_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire cbrd_pkg::req_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output cbrd_pkg::rsp_t      m_data
);

    import cbrd_pkg::*;

`include "console_bus_region_decoder_core_macros.svh"

    // address widths of each memory
    localparam int unsigned CAW = $clog2(CLUT_WORDS);
    localparam int unsigned LAW = (LINE_WORDS > 1) ? $clog2(LINE_WORDS) : 1;
    localparam int unsigned GAW = $clog2(GPU_RAM_WORDS);
    localparam int unsigned DAW = $clog2(DSP_RAM_WORDS);
    localparam int unsigned RAW = (ROM_WORDS > 1) ? $clog2(ROM_WORDS) : 1;

    // clear sweep covers the deepest zero-reset memory
    localparam int unsigned CLR_A   = (LINE_WORDS > CLUT_WORDS) ? LINE_WORDS : CLUT_WORDS;
    localparam int unsigned CLR_B   = (GPU_RAM_WORDS > DSP_RAM_WORDS) ? GPU_RAM_WORDS
                                                                      : DSP_RAM_WORDS;
    localparam int unsigned CLR_LEN = (CLR_A > CLR_B) ? CLR_A : CLR_B;
    localparam int unsigned CLW     = $clog2(CLR_LEN);

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    logic [16:0] rom_words_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_words_reg <= ROM_WORDS_RESET;
        end else if (cfg_wr_en) begin
            rom_words_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // clear sweep after reset
    // ------------------------------------------------------------------------
    logic           clearing_reg, clearing_next;
    logic [CLW-1:0] clr_cnt_reg, clr_cnt_next;

    always_comb begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg) begin
            if (clr_cnt_reg == CLW'(CLR_LEN - 1)) begin
                clearing_next = 1'b0;
            end else begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_cnt_reg  <= clr_cnt_next;
        end
    end

    // ------------------------------------------------------------------------
    // request decode (acceptance cycle)
    // ------------------------------------------------------------------------
    logic           s1_valid_reg, s1_valid_next;
    logic           m_valid_reg, m_valid_next;
    logic           s_fire, s1_fire;

    logic [2:0]     in_region;
    logic [9:0]     in_line_word;
    logic           in_line_ok;
    logic           in_load_ok;
    logic [16:0]    rom_mask;
    logic [CAW-1:0] in_clut_idx;
    logic [LAW-1:0] in_line_idx;
    logic [GAW-1:0] in_gpu_idx;
    logic [DAW-1:0] in_dsp_idx;
    logic [RAW-1:0] in_rom_idx;
    logic [15:0]    in_wdata;

    assign s_ready = !clearing_reg && !s1_valid_reg;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        in_region    = decode_region(s_data.address);
        in_line_word = s_data.address[10:1];
        in_line_ok   = ({1'b0, in_line_word} < 11'(LINE_WORDS));
        in_load_ok   = (s_data.address < 24'(ROM_WORDS));
        rom_mask     = rom_words_reg - 17'd1;
        in_clut_idx  = s_data.address[CAW:1];
        in_line_idx  = in_line_word[LAW-1:0];
        in_gpu_idx   = s_data.address[GAW+1:2] & GAW'(GPU_RAM_WORDS - 1);
        in_dsp_idx   = s_data.address[DAW+1:2] & DAW'(DSP_RAM_WORDS - 1);
        if (s_data.kind == KIND_ROM_LOAD) begin
            in_rom_idx = s_data.address[RAW-1:0];
        end else begin
            in_rom_idx = s_data.address[RAW:1] & rom_mask[RAW-1:0] & RAW'(ROM_WORDS - 1);
        end
        // byte writes repeat the byte into both halves
        if (s_data.kind == KIND_BYTE_WRITE) begin
            in_wdata = {s_data.write_data[7:0], s_data.write_data[7:0]};
        end else begin
            in_wdata = s_data.write_data;
        end
    end

    // ------------------------------------------------------------------------
    // working stage: holds the request while its memory read returns
    // ------------------------------------------------------------------------
    logic [2:0]     kind_reg;
    logic [1:0]     alow_reg;
    logic [2:0]     region_reg;
    logic           line_ok_reg;
    logic           load_ok_reg;
    logic [CAW-1:0] clut_idx_reg;
    logic [LAW-1:0] line_idx_reg;
    logic [GAW-1:0] gpu_idx_reg;
    logic [DAW-1:0] dsp_idx_reg;
    logic [RAW-1:0] rom_idx_reg;
    logic [15:0]    wdata_reg;

    assign s1_fire       = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s1_valid_next = s_fire || (s1_valid_reg && !s1_fire);
    assign m_valid_next  = s1_fire || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg     <= s_data.kind;
            alow_reg     <= s_data.address[1:0];
            region_reg   <= in_region;
            line_ok_reg  <= in_line_ok;
            load_ok_reg  <= in_load_ok;
            clut_idx_reg <= in_clut_idx;
            line_idx_reg <= in_line_idx;
            gpu_idx_reg  <= in_gpu_idx;
            dsp_idx_reg  <= in_dsp_idx;
            rom_idx_reg  <= in_rom_idx;
            wdata_reg    <= in_wdata;
        end
    end

    // ------------------------------------------------------------------------
    // memories
    // ------------------------------------------------------------------------
    logic [15:0] clut_rdata, la_rdata, lb_rdata, lw_rdata, rom_rdata;
    logic [31:0] gpu_rdata, dsp_rdata;

    logic        clut_we, la_we, lb_we, lw_we, gpu_we, dsp_we, rom_we;
    logic [15:0] line_wdata;
    logic [31:0] gpu_wdata, dsp_wdata;
    logic [31:0] gpu_merged, dsp_merged;

    logic        is_write, is_line;
    logic        write_ok, read_ok;
    logic [15:0] word_val;
    rsp_t        rsp;

    always_comb begin
        is_write = (kind_reg == KIND_WORD_WRITE) || (kind_reg == KIND_BYTE_WRITE);
        is_line  = (region_reg == REGION_LA) || (region_reg == REGION_LB) ||
                   (region_reg == REGION_LW);
        write_ok = (region_reg == REGION_CLUT) || (region_reg == REGION_GPU) ||
                   (region_reg == REGION_DSP) || (is_line && line_ok_reg);
        read_ok  = write_ok || (region_reg == REGION_ROM);

        // bit 1 clear selects the high half of a 32-bit RAM word
        gpu_merged = alow_reg[1] ? {gpu_rdata[31:16], wdata_reg}
                                 : {wdata_reg, gpu_rdata[15:0]};
        dsp_merged = alow_reg[1] ? {dsp_rdata[31:16], wdata_reg}
                                 : {wdata_reg, dsp_rdata[15:0]};

        case (region_reg)
            REGION_ROM:  word_val = rom_rdata;
            REGION_CLUT: word_val = clut_rdata;
            REGION_LA:   word_val = line_ok_reg ? la_rdata : NO_DATA;
            REGION_LB:   word_val = line_ok_reg ? lb_rdata : NO_DATA;
            REGION_LW:   word_val = line_ok_reg ? lw_rdata : NO_DATA;
            REGION_GPU:  word_val = alow_reg[1] ? gpu_rdata[15:0] : gpu_rdata[31:16];
            REGION_DSP:  word_val = alow_reg[1] ? dsp_rdata[15:0] : dsp_rdata[31:16];
            default:     word_val = NO_DATA;
        endcase

        case (kind_reg)
            KIND_WORD_WRITE, KIND_BYTE_WRITE: begin
                rsp.read_data = '0;
                rsp.status    = !write_ok;
            end
            KIND_WORD_READ: begin
                rsp.read_data = word_val;
                rsp.status    = !read_ok;
            end
            KIND_BYTE_READ: begin
                rsp.read_data = {8'h00, (alow_reg[0] ? word_val[7:0] : word_val[15:8])};
                rsp.status    = !read_ok;
            end
            KIND_ROM_LOAD: begin
                rsp.read_data = '0;
                rsp.status    = !load_ok_reg;
            end
            default: begin
                rsp.read_data = '0;
                rsp.status    = 1'b1;
            end
        endcase

        // write back on completion; the sweep owns the ports while clearing
        clut_we = s1_fire && is_write && (region_reg == REGION_CLUT);
        la_we   = s1_fire && is_write && (region_reg == REGION_LA) && line_ok_reg;
        lb_we   = s1_fire && is_write && (region_reg == REGION_LB) && line_ok_reg;
        lw_we   = s1_fire && is_write && (region_reg == REGION_LW) && line_ok_reg;
        gpu_we  = s1_fire && is_write && (region_reg == REGION_GPU);
        dsp_we  = s1_fire && is_write && (region_reg == REGION_DSP);
        rom_we  = s1_fire && (kind_reg == KIND_ROM_LOAD) && load_ok_reg;

        line_wdata = clearing_reg ? 16'h0000 : wdata_reg;
        gpu_wdata  = clearing_reg ? 32'h0 : gpu_merged;
        dsp_wdata  = clearing_reg ? 32'h0 : dsp_merged;
    end

    logic clr_clut, clr_line, clr_gpu, clr_dsp;

    assign clr_clut = clearing_reg && ({1'b0, clr_cnt_reg} < (CLW + 1)'(CLUT_WORDS));
    assign clr_line = clearing_reg && ({1'b0, clr_cnt_reg} < (CLW + 1)'(LINE_WORDS));
    assign clr_gpu  = clearing_reg && ({1'b0, clr_cnt_reg} < (CLW + 1)'(GPU_RAM_WORDS));
    assign clr_dsp  = clearing_reg && ({1'b0, clr_cnt_reg} < (CLW + 1)'(DSP_RAM_WORDS));

    cbrd_ram #(.WIDTH(16), .DEPTH(CLUT_WORDS)) u_clut (
        .aclk  (aclk),
        .we    (clut_we || clr_clut),
        .waddr (clearing_reg ? clr_cnt_reg[CAW-1:0] : clut_idx_reg),
        .wdata (line_wdata),
        .re    (s_fire),
        .raddr (in_clut_idx),
        .rdata (clut_rdata)
    );

    cbrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_a (
        .aclk  (aclk),
        .we    (la_we || clr_line),
        .waddr (clearing_reg ? clr_cnt_reg[LAW-1:0] : line_idx_reg),
        .wdata (line_wdata),
        .re    (s_fire && in_line_ok),
        .raddr (in_line_idx),
        .rdata (la_rdata)
    );

    cbrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_b (
        .aclk  (aclk),
        .we    (lb_we || clr_line),
        .waddr (clearing_reg ? clr_cnt_reg[LAW-1:0] : line_idx_reg),
        .wdata (line_wdata),
        .re    (s_fire && in_line_ok),
        .raddr (in_line_idx),
        .rdata (lb_rdata)
    );

    cbrd_ram #(.WIDTH(16), .DEPTH(LINE_WORDS)) u_line_w (
        .aclk  (aclk),
        .we    (lw_we || clr_line),
        .waddr (clearing_reg ? clr_cnt_reg[LAW-1:0] : line_idx_reg),
        .wdata (line_wdata),
        .re    (s_fire && in_line_ok),
        .raddr (in_line_idx),
        .rdata (lw_rdata)
    );

    cbrd_ram #(.WIDTH(32), .DEPTH(GPU_RAM_WORDS)) u_gpu (
        .aclk  (aclk),
        .we    (gpu_we || clr_gpu),
        .waddr (clearing_reg ? clr_cnt_reg[GAW-1:0] : gpu_idx_reg),
        .wdata (gpu_wdata),
        .re    (s_fire),
        .raddr (in_gpu_idx),
        .rdata (gpu_rdata)
    );

    cbrd_ram #(.WIDTH(32), .DEPTH(DSP_RAM_WORDS)) u_dsp (
        .aclk  (aclk),
        .we    (dsp_we || clr_dsp),
        .waddr (clearing_reg ? clr_cnt_reg[DAW-1:0] : dsp_idx_reg),
        .wdata (dsp_wdata),
        .re    (s_fire),
        .raddr (in_dsp_idx),
        .rdata (dsp_rdata)
    );

    // boot ROM: filled by load requests only, never swept
    cbrd_ram #(.WIDTH(16), .DEPTH(ROM_WORDS)) u_rom (
        .aclk  (aclk),
        .we    (rom_we),
        .waddr (rom_idx_reg),
        .wdata (wdata_reg),
        .re    (s_fire),
        .raddr (in_rom_idx),
        .rdata (rom_rdata)
    );

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    rsp_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `CBRD_ASSERT_NOW(a_no_req_while_clearing, aclk, aresetn, clearing_reg, !s_ready)
    `CBRD_ASSERT_NEXT(a_req_enters_stage, aclk, aresetn, s_fire, s1_valid_reg)
    `CBRD_ASSERT_NEXT(a_stage_to_output, aclk, aresetn, s1_fire, m_valid_reg)
    `CBRD_ASSERT_NOW(a_no_write_on_accept, aclk, aresetn, s_fire,
                     !(clut_we || la_we || lb_we || lw_we || gpu_we || dsp_we || rom_we))

endmodule

`default_nettype wire

### rtl/cbrd_ram.sv
// ----------------------------------------------------------------------------
// cbrd_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cbrd_ram #(
    parameter  int unsigned WIDTH = 16,
    parameter  int unsigned DEPTH = 256,
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
